FILE: hw/rtl/two_adic_float_alu_assert.svh
// assertion macros for the 2-adic float alu rtl
`ifndef TWO_ADIC_FLOAT_ALU_ASSERT_SVH
`define TWO_ADIC_FLOAT_ALU_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TAO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TAO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tao_pkg.sv
// shared types, widths and codes for the 2-adic float alu
package tao_pkg;

    localparam int SIG_BITS  = 44;
    localparam int EXP_BITS  = 20;
    localparam int WORD_BITS = SIG_BITS + EXP_BITS;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [SIG_BITS-1:0]  t_sig;
    typedef logic [EXP_BITS-1:0]  t_exp;
    typedef logic [2:0]           t_cmd;

    localparam t_cmd CMD_ADD = 3'd0;
    localparam t_cmd CMD_SUB = 3'd1;
    localparam t_cmd CMD_NEG = 3'd2;
    localparam t_cmd CMD_MUL = 3'd3;
    localparam t_cmd CMD_DIV = 3'd4;
    localparam t_cmd CMD_CMP = 3'd5;

    localparam t_word POS_INF_RESET = 64'h7FFF_F7FF_FFFF_FFFF;
    localparam t_word NEG_INF_RESET = 64'h8000_0800_0000_0000;

    // request to the multiply / divide unit
    typedef struct packed {
        logic go;
        logic div;
    } t_md_req;

    // magnitude of the two's-complement significand field
    function automatic t_sig sig_mag(input t_word w);
        t_sig s;
        s = w[SIG_BITS-1:0];
        return s[SIG_BITS-1] ? t_sig'(t_sig'(0) - s) : s;
    endfunction

endpackage

FILE: hw/rtl/tao_align_add.sv
// bit-serial aligned adder with trailing-zero normalisation
module tao_align_add (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  tao_pkg::t_word i_a,
    input  tao_pkg::t_word i_b,
    output logic          o_done,
    output tao_pkg::t_word o_word
);
    import tao_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_NORM = 2'd2;
    localparam int TZ_CAP = SIG_BITS - 1;

    logic [1:0]          r_state;
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] r_dist;
    logic [CNT_BITS-1:0] r_t;
    t_word               r_x;
    t_word               r_y;
    t_word               r_acc;
    logic                r_carry;
    logic                r_nz;
    t_exp                r_exp;
    logic                r_done;
    t_word               r_word;

    t_exp  ea;
    t_exp  eb;
    t_exp  exp_gap;
    logic  a_gt;
    logic  far;
    t_word sa;
    t_word sb;
    logic  x_live;
    logic  xb;
    logic  sbit;
    logic  cbit;

    assign ea      = i_a[WORD_BITS-1:SIG_BITS];
    assign eb      = i_b[WORD_BITS-1:SIG_BITS];
    assign a_gt    = $signed(ea) > $signed(eb);
    assign exp_gap = a_gt ? t_exp'(ea - eb) : t_exp'(eb - ea);
    assign far     = |exp_gap[EXP_BITS-1:CNT_BITS];
    assign sa      = {{EXP_BITS{i_a[SIG_BITS-1]}}, i_a[SIG_BITS-1:0]};
    assign sb      = {{EXP_BITS{i_b[SIG_BITS-1]}}, i_b[SIG_BITS-1:0]};

    // the shifted operand starts exp_gap bits late in the stream
    assign x_live = r_cnt >= r_dist;
    assign xb     = x_live & r_x[0];
    assign sbit   = xb ^ r_y[0] ^ r_carry;
    assign cbit   = (xb & r_y[0]) | (xb & r_carry) | (r_y[0] & r_carry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_go) begin
                        r_x     <= far ? t_word'(0) : (a_gt ? sa : sb);
                        r_y     <= a_gt ? sb : sa;
                        r_exp   <= a_gt ? eb : ea;
                        r_dist  <= exp_gap[CNT_BITS-1:0];
                        r_cnt   <= '0;
                        r_carry <= 1'b0;
                        r_nz    <= 1'b0;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_acc   <= {sbit, r_acc[WORD_BITS-1:1]};
                    r_y     <= {1'b0, r_y[WORD_BITS-1:1]};
                    if (x_live) begin
                        r_x <= {1'b0, r_x[WORD_BITS-1:1]};
                    end
                    r_carry <= cbit;
                    r_nz    <= r_nz | sbit;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(WORD_BITS - 1)) begin
                        r_t     <= '0;
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (!r_nz) begin
                        r_word  <= '0;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else if (!r_acc[0] && (r_t != CNT_BITS'(TZ_CAP))) begin
                        r_acc <= {r_acc[WORD_BITS-1], r_acc[WORD_BITS-1:1]};
                        r_t   <= r_t + 1'b1;
                    end else begin
                        r_word  <= {t_exp'(r_exp + EXP_BITS'(r_t)), r_acc[SIG_BITS-1:0]};
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_word = r_word;

endmodule

FILE: hw/rtl/tao_muldiv.sv
// shift-add multiplier and bit-serial 2-adic divider
module tao_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tao_pkg::t_md_req i_req,
    input  tao_pkg::t_word   i_a,
    input  tao_pkg::t_word   i_b,
    output logic             o_done,
    output tao_pkg::t_word   o_word
);
    import tao_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_MNORM = 3'd2;
    localparam logic [2:0] ST_DTZ   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]          r_state;
    logic [CNT_BITS-1:0] r_cnt;
    t_sig                r_hi;
    t_sig                r_lo;
    t_sig                r_mc;
    t_exp                r_exp;
    logic                r_neg;
    logic                r_zero;
    logic                r_done;
    t_word               r_word;

    t_sig            ma;
    t_sig            mb;
    t_exp            ea;
    t_exp            eb;
    logic [SIG_BITS:0] psum;
    t_sig            qdiff;
    logic            qbit;

    assign ma = sig_mag(i_a);
    assign mb = sig_mag(i_b);
    assign ea = i_a[WORD_BITS-1:SIG_BITS];
    assign eb = i_b[WORD_BITS-1:SIG_BITS];

    // one multiplier bit per cycle
    assign psum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mc} : '0);
    // one quotient bit per cycle: low remainder bit decides
    assign qbit  = r_hi[0];
    assign qdiff = qbit ? t_sig'(r_hi - r_mc) : r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_req.go) begin
                        r_neg <= i_a[SIG_BITS-1] ^ i_b[SIG_BITS-1];
                        r_cnt <= '0;
                        if (i_req.div) begin
                            r_hi    <= ma;
                            r_mc    <= mb;
                            r_lo    <= '0;
                            r_exp   <= t_exp'(ea - eb);
                            r_state <= ST_DTZ;
                        end else begin
                            r_hi    <= '0;
                            r_lo    <= mb;
                            r_mc    <= ma;
                            r_exp   <= t_exp'(ea + eb);
                            r_zero  <= (ma == '0) || (mb == '0);
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_hi  <= psum[SIG_BITS:1];
                    r_lo  <= {psum[0], r_lo[SIG_BITS-1:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(SIG_BITS - 1)) begin
                        r_state <= ST_MNORM;
                    end
                end
                ST_MNORM: begin
                    if (r_zero || r_lo[0]) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_hi  <= {1'b0, r_hi[SIG_BITS-1:1]};
                        r_lo  <= {r_hi[0], r_lo[SIG_BITS-1:1]};
                        r_exp <= r_exp + 1'b1;
                    end
                end
                ST_DTZ: begin
                    if (r_mc[0]) begin
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_mc  <= {1'b0, r_mc[SIG_BITS-1:1]};
                        r_exp <= r_exp - 1'b1;
                    end
                end
                ST_DIV: begin
                    r_hi  <= {1'b0, qdiff[SIG_BITS-1:1]};
                    r_lo  <= {qbit, r_lo[SIG_BITS-1:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(SIG_BITS - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_word  <= {r_exp, r_neg ? t_sig'(t_sig'(0) - r_lo) : r_lo};
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_word = r_word;

endmodule

FILE: hw/rtl/two_adic_float_alu.sv
// top level of the 2-adic floating word arithmetic unit
//
// command channel: a beat is taken at a rising edge with start high and busy
// low; i_command selects add, subtract, negate b, multiply, divide or compare
// on i_operand_a / i_operand_b (exponent above the 44-bit significand).
// result channel: o_strobe is high for exactly one cycle with o_result_word
// and o_order; the receiver cannot stall, so nothing is held back.
// config channel: i_cfg_valid with o_cfg_ready (always high) writes the
// positive (index 0) or negative (index 1) infinity word; write only when idle.
// result path from the accepting edge to the strobe:
//   negate, compare, unused codes, divide by zero: strobe the cycle after
//   add / subtract: the 64-step bit-serial adder, then one normalising shift
//     per cycle for each trailing zero of the sum (0..43)
//   multiply: the 44-step shift-add loop, then the normalising shifter for
//     each trailing zero of the product (0..86)
//   divide: the divisor's trailing zeros (0..43) shifted out, then the
//     44-step 2-adic quotient loop
// busy stays high while a serial unit runs; one item is in flight at a time.
// reset (synchronous, active low) clears busy and the strobe and reloads
// the infinity registers with their defaults.
`include "two_adic_float_alu_assert.svh"

module two_adic_float_alu (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tao_pkg::t_cmd   i_command,
    input  tao_pkg::t_word  i_operand_a,
    input  tao_pkg::t_word  i_operand_b,
    output logic            o_strobe,
    output tao_pkg::t_word  o_result_word,
    output logic signed [1:0] o_order,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  tao_pkg::t_word  i_cfg_data
);
    import tao_pkg::*;

    // compare outcome codes
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;
    localparam logic [1:0] ORD_LT = 2'b11;

    // config register indexes
    localparam logic REG_POS_INF = 1'b0;
    localparam logic REG_NEG_INF = 1'b1;

    logic        r_busy;
    logic        r_strobe;
    t_word       r_word;
    logic [1:0]  r_order;
    t_word       r_pos_inf;
    t_word       r_neg_inf;

    logic        accept;
    logic        cfg_wr;
    t_word       b_neg;
    logic        b_zero;
    logic        add_go;
    t_word       add_b;
    logic        add_done;
    t_word       add_word;
    t_md_req     md_req;
    logic        md_done;
    t_word       md_word;
    logic [1:0]  cmp_ord;
    t_exp        ea_raw;
    t_exp        eb_raw;
    logic        quick_cmd;

    assign accept = start & ~r_busy;
    assign cfg_wr = i_cfg_valid & o_cfg_ready;

    // negated b keeps its exponent, significand negated modulo the field
    assign b_neg  = {i_operand_b[WORD_BITS-1:SIG_BITS],
                     t_sig'(t_sig'(0) - i_operand_b[SIG_BITS-1:0])};
    assign b_zero = (i_operand_b[SIG_BITS-1:0] == '0);

    // add and subtract share the serial adder
    assign add_go = accept && ((i_command == CMD_ADD) || (i_command == CMD_SUB));
    assign add_b  = (i_command == CMD_SUB) ? b_neg : i_operand_b;

    // divide by zero never reaches the divider
    assign md_req.go  = accept && ((i_command == CMD_MUL) ||
                                   ((i_command == CMD_DIV) && !b_zero));
    assign md_req.div = (i_command == CMD_DIV);

    // negate and compare commands accepted this edge
    assign quick_cmd = accept && ((i_command == CMD_NEG) || (i_command == CMD_CMP));

    // raw field ordering: equal words first, then exponents, then significands, all unsigned
    assign ea_raw = i_operand_a[WORD_BITS-1:SIG_BITS];
    assign eb_raw = i_operand_b[WORD_BITS-1:SIG_BITS];
    always_comb begin
        if (i_operand_a == i_operand_b) begin
            cmp_ord = ORD_EQ;
        end else if (ea_raw > eb_raw) begin
            cmp_ord = ORD_GT;
        end else if (ea_raw < eb_raw) begin
            cmp_ord = ORD_LT;
        end else if (i_operand_a[SIG_BITS-1:0] > i_operand_b[SIG_BITS-1:0]) begin
            cmp_ord = ORD_GT;
        end else begin
            cmp_ord = ORD_LT;
        end
    end

    tao_align_add u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (add_go),
        .i_a     (i_operand_a),
        .i_b     (add_b),
        .o_done  (add_done),
        .o_word  (add_word)
    );

    tao_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .o_done  (md_done),
        .o_word  (md_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_strobe  <= 1'b0;
            r_pos_inf <= POS_INF_RESET;
            r_neg_inf <= NEG_INF_RESET;
        end else begin
            r_strobe <= 1'b0;
            if (cfg_wr) begin
                case (i_cfg_index)
                    REG_POS_INF: r_pos_inf <= i_cfg_data;
                    REG_NEG_INF: r_neg_inf <= i_cfg_data;
                    default: r_pos_inf <= r_pos_inf;
                endcase
            end
            if (accept) begin
                case (i_command)
                    CMD_ADD, CMD_SUB, CMD_MUL: begin
                        r_busy <= 1'b1;
                    end
                    CMD_DIV: begin
                        if (b_zero) begin
                            r_word   <= i_operand_a[SIG_BITS-1] ? r_neg_inf : r_pos_inf;
                            r_order  <= ORD_EQ;
                            r_strobe <= 1'b1;
                        end else begin
                            r_busy <= 1'b1;
                        end
                    end
                    CMD_NEG: begin
                        r_word   <= b_neg;
                        r_order  <= ORD_EQ;
                        r_strobe <= 1'b1;
                    end
                    CMD_CMP: begin
                        r_word   <= '0;
                        r_order  <= cmp_ord;
                        r_strobe <= 1'b1;
                    end
                    default: begin
                        r_word   <= '0;
                        r_order  <= ORD_EQ;
                        r_strobe <= 1'b1;
                    end
                endcase
            end else if (add_done) begin
                r_word   <= add_word;
                r_order  <= ORD_EQ;
                r_strobe <= 1'b1;
                r_busy   <= 1'b0;
            end else if (md_done) begin
                r_word   <= md_word;
                r_order  <= ORD_EQ;
                r_strobe <= 1'b1;
                r_busy   <= 1'b0;
            end
        end
    end

    assign busy          = r_busy;
    assign o_strobe      = r_strobe;
    assign o_result_word = r_word;
    assign o_order       = r_order;
    assign o_cfg_ready   = 1'b1;

    // a serial unit only finishes an item that the top level is waiting on
    `TAO_ASSERT_NOW(a_done_while_busy, add_done || md_done, r_busy, "unit finished while idle")
    // the two serial units never finish together
    `TAO_ASSERT_NOW(a_single_done, 1'b1, $onehot0({add_done, md_done}), "both units finished")
    // short commands give their beat on the next cycle and leave the block free
    `TAO_ASSERT_NEXT(a_quick_beat, quick_cmd, o_strobe && !busy, "short command beat missing")
    // the divider is never started on a zero divisor
    `TAO_ASSERT_NOW(a_div_nonzero, md_req.go && md_req.div, !b_zero, "divider started on zero")

endmodule
